// ===== design/kmp_pkg.sv =====
// Package for the token matcher: shared constants, status codes and controller states.
`timescale 1ns / 1ps
`default_nettype none
package kmp_pkg;

	localparam int PATTERN_DEPTH_DEF = 256;
	localparam int POSITION_BITS_DEF = 20;
	localparam int TOKEN_W = 33;
	localparam int STATUS_W = 3;
	localparam int LEN_W = 9;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_MATCH      = 3'd1,
		ST_FULL       = 3'd2,
		ST_TOO_LONG   = 3'd3,
		ST_NO_PATTERN = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_FAIL,
		S_TAIL,
		S_COMMIT
	} fsm_t;

endpackage
`default_nettype wire

// ===== design/kmp_in_if.sv =====
// Input channel: one token beat with its function and last mark.
`timescale 1ns / 1ps
`default_nettype none
interface kmp_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [31:0] token_value;
	logic               token_null;
	logic               last;

	modport source (output valid, func, token_value, token_null, last, input ready);
	modport sink (input valid, func, token_value, token_null, last, output ready);
endinterface
`default_nettype wire

// ===== design/kmp_out_if.sv =====
// Result channel: one status beat per accepted token.
`timescale 1ns / 1ps
`default_nettype none
interface kmp_out_if #(
	parameter int POS_W = kmp_pkg::POSITION_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [kmp_pkg::STATUS_W-1:0] status;
	logic                         found;
	logic [POS_W-1:0]             match_start;
	logic [kmp_pkg::LEN_W-1:0]    pattern_length;
	logic                         end_of_text;

	modport source (output valid, status, found, match_start, pattern_length, end_of_text,
		input ready);
	modport sink (input valid, status, found, match_start, pattern_length, end_of_text,
		output ready);
endinterface
`default_nettype wire

// ===== design/kmp_token_matcher.sv =====
// Top level of the token matcher: controller, walk datapath and the two tables.
//
//  channel   modport   beat contents
//  token     sink      func, token_value, token_null, last
//  result    source    status, found, match_start, pattern_length, end_of_text
//
// A walking item is settled in the compare step; each failure link it follows adds a
// fail step, and a text token that completes a full match adds a tail step. Each link
// reads the failure table, then the pattern table; both tables have registered reads.
// One item is in work at a time; a finished result waits in the output register, and the
// next token is taken while it waits. A stalled result holds the commit step.
// Reset clears the control state at once; the tables are not cleared and are read only
// below the loaded pattern length.
`timescale 1ns / 1ps
`default_nettype none
module kmp_token_matcher #(
	parameter int PATTERN_DEPTH = kmp_pkg::PATTERN_DEPTH_DEF,
	parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	kmp_in_if.sink    token,
	kmp_out_if.source result
);
	import kmp_pkg::*;

	localparam int IW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int CW = $clog2(PATTERN_DEPTH + 1);
	localparam int PW = POSITION_BITS;
	localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
	localparam logic [CW-1:0] DEPTH_C = CW'(PATTERN_DEPTH);

	fsm_t state_q, state_n;

	// Item under work.
	logic [TOKEN_W-1:0] tok_q;
	logic               func_q;
	logic               last_q;
	status_t            status_q;
	logic [IW-1:0]      k_q;
	logic               hit_q;

	// Pattern and text state.
	logic [CW-1:0] count_q;
	logic [IW-1:0] prefix_q;
	logic          done_q;
	logic [IW-1:0] midx_q;
	logic [PW-1:0] pos_q;
	logic          found_q;
	logic [PW-1:0] first_q;

	// Output register.
	logic             out_valid_q;
	status_t          o_status_q;
	logic             o_found_q;
	logic [PW-1:0]    o_start_q;
	logic [LEN_W-1:0] o_len_q;
	logic             o_eot_q;

	// Table ports.
	logic               pat_we;
	logic [IW-1:0]      pat_waddr;
	logic [TOKEN_W-1:0] pat_wdata;
	logic [IW-1:0]      pat_raddr;
	logic [TOKEN_W-1:0] pat_rd;
	logic               fail_we;
	logic [IW-1:0]      fail_waddr;
	logic [IW-1:0]      fail_raddr;
	logic [IW-1:0]      fail_rd;

	// Accept decode.
	logic               accept;
	logic [TOKEN_W-1:0] in_tok;
	logic               clr;
	logic [CW-1:0]      cnt_eff;
	status_t            acc_status;
	logic               acc_walk;

	// Walk and commit.
	logic          tok_eq;
	logic [CW-1:0] k_inc;
	logic          walk_done;
	logic          need_tail;
	logic          slot_free;
	logic          commit_req;
	logic          commit;
	logic [IW-1:0] k_fin;

	logic [CW-1:0] count_c;
	logic [IW-1:0] prefix_c;
	logic [IW-1:0] midx_c;
	logic [PW-1:0] pos_c;
	logic          found_c;
	logic [PW-1:0] first_c;
	status_t       status_c;

	kmp_ram #(
		.WIDTH (TOKEN_W),
		.DEPTH (PATTERN_DEPTH),
		.AW    (IW)
	) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (pat_wdata),
		.raddr (pat_raddr),
		.rdata (pat_rd)
	);

	kmp_ram #(
		.WIDTH (IW),
		.DEPTH (PATTERN_DEPTH),
		.AW    (IW)
	) u_fail_ram (
		.clk   (clk),
		.we    (fail_we),
		.waddr (fail_waddr),
		.wdata (prefix_c),
		.raddr (fail_raddr),
		.rdata (fail_rd)
	);

	assign accept    = token.valid && token.ready;
	assign slot_free = !out_valid_q || result.ready;
	assign commit    = commit_req && slot_free;

	always_comb begin
		in_tok   = {token.token_null, token.token_null ? 32'd0 : token.token_value};
		clr      = !token.func && done_q;
		cnt_eff  = clr ? '0 : count_q;
		acc_status = ST_OK;
		acc_walk   = 1'b0;
		if (!token.func) begin
			if (cnt_eff >= DEPTH_C) begin
				acc_status = ST_FULL;
			end else if (cnt_eff != '0) begin
				acc_walk = 1'b1;
			end
		end else begin
			if (!done_q || count_q == '0) begin
				acc_status = ST_NO_PATTERN;
			end else if (pos_q >= POS_MAX) begin
				acc_status = ST_TOO_LONG;
			end else begin
				acc_walk = 1'b1;
			end
		end
	end

	always_comb begin
		tok_eq    = (pat_rd == tok_q);
		k_inc     = CW'(k_q) + CW'(1);
		walk_done = tok_eq || (k_q == '0);
		need_tail = func_q && walk_done && ((tok_eq ? k_inc : CW'(k_q)) == count_q);
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_n = acc_walk ? S_CMP : S_COMMIT;
				end
			end
			S_CMP: begin
				if (!walk_done) begin
					state_n = S_FAIL;
				end else if (need_tail) begin
					state_n = S_TAIL;
				end else begin
					state_n = slot_free ? S_IDLE : S_COMMIT;
				end
			end
			S_FAIL: begin
				state_n = S_CMP;
			end
			S_TAIL, S_COMMIT: begin
				state_n = slot_free ? S_IDLE : S_COMMIT;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Controller outputs: table addresses, write strobes and the commit request.
	always_comb begin
		token.ready = 1'b0;
		pat_we      = 1'b0;
		pat_waddr   = cnt_eff[IW-1:0];
		pat_wdata   = in_tok;
		pat_raddr   = token.func ? midx_q : prefix_q;
		fail_raddr  = k_q - IW'(1);
		commit_req  = 1'b0;
		k_fin       = k_q;
		case (state_q)
			S_IDLE: begin
				token.ready = 1'b1;
				pat_we      = token.valid && !token.func && (cnt_eff < DEPTH_C);
			end
			S_CMP: begin
				if (need_tail) begin
					fail_raddr = IW'(count_q - CW'(1));
				end
				commit_req = walk_done && !need_tail;
				k_fin      = tok_eq ? k_inc[IW-1:0] : k_q;
			end
			S_FAIL: begin
				pat_raddr = fail_rd;
			end
			S_TAIL: begin
				commit_req = 1'b1;
				k_fin      = fail_rd;
			end
			S_COMMIT: begin
				commit_req = 1'b1;
			end
			default: begin
				commit_req = 1'b0;
			end
		endcase
		fail_we    = commit && !func_q && (status_q != ST_FULL);
		fail_waddr = count_q[IW-1:0];
	end

	// State after this item, before the end-of-text clear.
	always_comb begin
		count_c  = count_q;
		prefix_c = prefix_q;
		midx_c   = midx_q;
		pos_c    = pos_q;
		found_c  = found_q;
		first_c  = first_q;
		status_c = status_q;
		if (!func_q) begin
			if (status_q != ST_FULL) begin
				prefix_c = (count_q == '0) ? '0 : k_fin;
				count_c  = count_q + CW'(1);
			end
		end else if (status_q == ST_OK) begin
			midx_c = k_fin;
			pos_c  = pos_q + PW'(1);
			if (hit_q && !found_q) begin
				found_c  = 1'b1;
				first_c  = pos_q + PW'(1) - PW'(count_q);
				status_c = ST_MATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_OK;
			func_q      <= 1'b0;
			last_q      <= 1'b0;
			k_q         <= '0;
			hit_q       <= 1'b0;
			count_q     <= '0;
			prefix_q    <= '0;
			done_q      <= 1'b0;
			midx_q      <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			first_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				func_q   <= token.func;
				last_q   <= token.last;
				status_q <= acc_status;
				k_q      <= token.func ? midx_q : prefix_q;
				hit_q    <= 1'b0;
				if (clr) begin
					count_q  <= '0;
					prefix_q <= '0;
					done_q   <= 1'b0;
					midx_q   <= '0;
					pos_q    <= '0;
					found_q  <= 1'b0;
					first_q  <= '0;
				end
			end
			if (state_q == S_FAIL) begin
				k_q <= fail_rd;
			end
			if (state_q == S_CMP && need_tail) begin
				hit_q <= 1'b1;
			end
			if (commit_req && !slot_free) begin
				k_q <= k_fin;
			end
			if (commit) begin
				count_q  <= count_c;
				prefix_q <= prefix_c;
				if (!func_q && last_q) begin
					done_q <= 1'b1;
				end
				if (func_q && last_q) begin
					midx_q  <= '0;
					pos_q   <= '0;
					found_q <= 1'b0;
					first_q <= '0;
				end else begin
					midx_q  <= midx_c;
					pos_q   <= pos_c;
					found_q <= found_c;
					first_q <= first_c;
				end
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_q <= in_tok;
		end
		if (commit) begin
			o_status_q <= status_c;
			o_found_q  <= found_c;
			o_start_q  <= found_c ? first_c : '0;
			o_len_q    <= LEN_W'(count_c);
			o_eot_q    <= func_q && last_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = o_status_q;
	assign result.found          = o_found_q;
	assign result.match_start    = o_start_q;
	assign result.pattern_length = o_len_q;
	assign result.end_of_text    = o_eot_q;

`ifndef SYNTHESIS
	a_walk_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && func_q) |-> (CW'(k_q) < count_q))
		else $error("text walk index reached the pattern length");

	a_match_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && count_q != '0) |-> (CW'(midx_q) < count_q))
		else $error("match index out of the loaded pattern");

	a_prefix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (CW'(prefix_q) < count_q))
		else $error("border length not below the pattern length");

	a_first_before_pos: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (first_q < pos_q))
		else $error("first match start not behind the text position");

	a_item_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted item did not enter the work states");
`endif
endmodule
`default_nettype wire

// ===== design/kmp_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module kmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== tb/kmp_token_matcher_test.sv =====
// Self-checking testbench for the token matcher: pattern loads, text streaming and status.
`timescale 1ns / 1ps
module kmp_token_matcher_test;
	import kmp_pkg::*;

	localparam int POS_BITS = POSITION_BITS_DEF;
	localparam int POS_MAX = (1 << POS_BITS) - 1;
	localparam int DEPTH = PATTERN_DEPTH_DEF;
	localparam bit FN_PATTERN = 1'b0;
	localparam bit FN_TEXT = 1'b1;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;
	localparam int RANDOM_ITEMS = 400;

	typedef struct {
		status_t             status;
		bit                  found;
		logic [POS_BITS-1:0] start;
		logic [LEN_W-1:0]    plen;
		bit                  eot;
	} kmp_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kmp_in_if tok_if ();
	kmp_out_if #(.POS_W(POS_BITS)) res_if ();

	kmp_token_matcher #(
		.PATTERN_DEPTH(DEPTH),
		.POSITION_BITS(POS_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.token(tok_if),
		.result(res_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Matcher state as the block should hold it.
	logic [TOKEN_W-1:0] pat_tok [DEPTH];
	int                 border_len [DEPTH];
	int                 pat_len = 0;
	int                 build_k = 0;
	bit                 pat_closed = 1'b0;
	int                 walk_state = 0;
	int                 text_pos = 0;
	bit                 seen_match = 1'b0;
	int                 match_at = 0;

	kmp_result_t awaited_results [$];

	bit quiet = 1'b0;
	int errors = 0;
	int results_seen = 0;
	int first_matches = 0;
	int full_drops = 0;
	int overlong = 0;
	int without_pattern = 0;

	function automatic void clear_text_side();
		walk_state = 0;
		text_pos = 0;
		seen_match = 1'b0;
		match_at = 0;
	endfunction

	function automatic void advance_matcher(bit func, logic [31:0] value, bit is_null, bit last);
		logic [TOKEN_W-1:0] tok;
		status_t st;
		kmp_result_t r;
		int k;
		int j;
		tok = is_null ? {1'b1, 32'd0} : {1'b0, value};
		st = ST_OK;
		if (func == FN_PATTERN) begin
			if (pat_closed) begin
				pat_len = 0;
				build_k = 0;
				pat_closed = 1'b0;
				clear_text_side();
			end
			if (pat_len >= DEPTH) begin
				st = ST_FULL;
			end else begin
				pat_tok[pat_len] = tok;
				if (pat_len == 0) begin
					border_len[0] = 0;
					build_k = 0;
				end else begin
					k = build_k;
					while (k > 0 && pat_tok[k] != tok)
						k = border_len[k-1];
					if (pat_tok[k] == tok)
						k++;
					border_len[pat_len] = k;
					build_k = k;
				end
				pat_len++;
			end
			if (last)
				pat_closed = 1'b1;
		end else begin
			if (!pat_closed || pat_len == 0) begin
				st = ST_NO_PATTERN;
			end else if (text_pos >= POS_MAX) begin
				st = ST_TOO_LONG;
			end else begin
				j = (walk_state >= pat_len) ? 0 : walk_state;
				while (j > 0 && pat_tok[j] != tok)
					j = border_len[j-1];
				if (pat_tok[j] == tok)
					j++;
				if (j == pat_len) begin
					if (!seen_match) begin
						seen_match = 1'b1;
						match_at = text_pos + 1 - pat_len;
						st = ST_MATCH;
					end
					j = border_len[pat_len-1];
				end
				walk_state = j;
				text_pos++;
			end
		end
		r.status = st;
		r.found = seen_match;
		r.start = seen_match ? match_at[POS_BITS-1:0] : '0;
		r.plen = pat_len[LEN_W-1:0];
		r.eot = (func == FN_TEXT) && last;
		awaited_results.insert(awaited_results.size(), r);
		if (func == FN_TEXT && last)
			clear_text_side();
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Small values collide often, which keeps the failure links busy.
	function automatic logic [TOKEN_W-1:0] pick_symbol();
		case ($urandom_range(0, 5))
			0: return {1'b1, 32'd0};
			1, 2: return {1'b0, 32'($urandom_range(0, 3))};
			3: return {1'b0, ($urandom_range(0, 1) ? INT_MIN : INT_MAX)};
			default: return {1'b0, 32'($urandom)};
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int wanted);
		$display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, wanted);
		errors++;
	endtask

	// Valid is only lowered when a gap follows, so it never drops and rises in one step.
	task automatic send_token(bit func, logic [31:0] value, bit is_null, bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tok_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tok_if.valid <= 1'b1;
		tok_if.func <= func;
		tok_if.token_value <= value;
		tok_if.token_null <= is_null;
		tok_if.last <= last;
		do @(posedge clk); while (tok_if.ready !== 1'b1);
		advance_matcher(func, value, is_null, last);
	endtask

	// A null symbol goes out with a random value, which the block must ignore.
	task automatic send_symbol(bit func, logic [TOKEN_W-1:0] sym, bit last);
		send_token(func, sym[32] ? 32'($urandom) : sym[31:0], sym[32], last);
	endtask

	task automatic wait_drained();
		tok_if.valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Result side: bursts of ready and stalls, or always ready in quiet stretches.
	initial begin
		int hold;
		bit rdy;
		hold = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (quiet) begin
				res_if.ready <= 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else begin
				rdy = ($urandom_range(0, 2) != 0);
				hold = rdy ? $urandom_range(0, 6) : pick_gap();
				res_if.ready <= rdy;
			end
		end
	end

	always @(posedge clk) begin
		kmp_result_t want;
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result beat with no token pending", res_if.status, -1);
			end else begin
				want = awaited_results.pop_front();
				results_seen++;
				if (res_if.status !== want.status)
					report_mismatch("status", res_if.status, want.status);
				if (res_if.found !== want.found)
					report_mismatch("found", res_if.found, want.found);
				if (res_if.match_start !== want.start)
					report_mismatch("match_start", res_if.match_start, want.start);
				if (res_if.pattern_length !== want.plen)
					report_mismatch("pattern_length", res_if.pattern_length, want.plen);
				if (res_if.end_of_text !== want.eot)
					report_mismatch("end_of_text", res_if.end_of_text, want.eot);
				case (want.status)
					ST_MATCH: first_matches++;
					ST_FULL: full_drops++;
					ST_TOO_LONG: overlong++;
					ST_NO_PATTERN: without_pattern++;
					default: ;
				endcase
			end
		end
	end

	task automatic test_directed();
		// Text before any pattern exists is ignored, the last mark still echoed.
		send_token(FN_TEXT, 32'd5, 1'b0, 1'b0);
		send_token(FN_TEXT, INT_MAX, 1'b1, 1'b1);
		send_token(FN_PATTERN, INT_MIN, 1'b0, 1'b0);
		send_token(FN_PATTERN, INT_MAX, 1'b0, 1'b0);
		send_token(FN_PATTERN, INT_MIN, 1'b0, 1'b1);
		// Two overlapping matches: only the first one is reported.
		send_token(FN_TEXT, INT_MIN, 1'b0, 1'b0);
		send_token(FN_TEXT, INT_MAX, 1'b0, 1'b0);
		send_token(FN_TEXT, INT_MIN, 1'b0, 1'b0);
		send_token(FN_TEXT, INT_MAX, 1'b0, 1'b0);
		send_token(FN_TEXT, INT_MIN, 1'b0, 1'b0);
		send_token(FN_TEXT, 32'd0, 1'b0, 1'b0);
		send_token(FN_TEXT, 32'd0, 1'b1, 1'b1);
		// A new pattern replaces the finished one; text during its load is ignored.
		send_token(FN_PATTERN, 32'h1234_5678, 1'b1, 1'b0);
		send_token(FN_PATTERN, MINUS_ONE, 1'b0, 1'b0);
		send_token(FN_PATTERN, 32'hdead_beef, 1'b1, 1'b0);
		send_token(FN_TEXT, MINUS_ONE, 1'b0, 1'b0);
		send_token(FN_PATTERN, 32'd0, 1'b0, 1'b1);
		send_token(FN_TEXT, 32'd7, 1'b1, 1'b0);
		send_token(FN_TEXT, MINUS_ONE, 1'b0, 1'b0);
		send_token(FN_TEXT, 32'd0, 1'b1, 1'b0);
		send_token(FN_TEXT, MINUS_ONE, 1'b0, 1'b0);
		send_token(FN_TEXT, 32'd9, 1'b1, 1'b0);
		send_token(FN_TEXT, 32'd0, 1'b0, 1'b1);
	endtask

	task automatic test_pattern_full();
		// Alternating zero and null, two tokens past the table depth.
		for (int i = 0; i < DEPTH + 2; i++)
			send_token(FN_PATTERN, 32'($urandom) & {32{i[0]}}, i[0], i == DEPTH + 1);
		for (int i = 0; i < DEPTH + 8; i++)
			send_token(FN_TEXT, 32'($urandom) & {32{i[0]}}, i[0], i == DEPTH + 7);
		wait_drained();
	endtask

	task automatic test_random();
		logic [TOKEN_W-1:0] alpha [4];
		logic [TOKEN_W-1:0] pat [$];
		logic [TOKEN_W-1:0] txt [$];
		int n_alpha;
		int plen;
		int tlen;
		int at;
		int kind;
		int r;
		int n;
		int m;
		int counted;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			quiet = ($urandom_range(0, 7) == 0);
			n_alpha = $urandom_range(1, 3);
			for (int a = 0; a < 4; a++)
				alpha[a] = pick_symbol();
			kind = $urandom_range(0, 99);
			if (kind < 84) begin
				r = $urandom_range(0, 99);
				plen = (r < 85) ? $urandom_range(1, 6) :
					(r < 97) ? $urandom_range(7, 24) : $urandom_range(25, 60);
				pat.delete();
				repeat (plen)
					pat.insert(pat.size(), alpha[$urandom_range(0, n_alpha - 1)]);
				tlen = $urandom_range(1, 50);
				txt.delete();
				repeat (tlen)
					txt.insert(txt.size(), alpha[$urandom_range(0, n_alpha - 1)]);
				// Plant copies of the pattern so that full matches are common.
				repeat ($urandom_range(0, 2)) begin
					if (plen <= tlen) begin
						at = $urandom_range(0, tlen - plen);
						foreach (pat[i])
							txt[at + i] = pat[i];
					end
				end
				foreach (pat[i])
					send_symbol(FN_PATTERN, pat[i], i == plen - 1);
				foreach (txt[i])
					send_symbol(FN_TEXT, txt[i], i == tlen - 1);
				counted += plen + tlen;
			end else if (kind < 93) begin
				// An unfinished pattern followed by text that must be ignored.
				n = $urandom_range(1, 4);
				m = $urandom_range(1, 4);
				repeat (n)
					send_symbol(FN_PATTERN, alpha[$urandom_range(0, n_alpha - 1)], 1'b0);
				repeat (m)
					send_symbol(FN_TEXT, alpha[$urandom_range(0, n_alpha - 1)],
						$urandom_range(0, 3) == 0);
				counted += n + m;
			end else begin
				n = $urandom_range(1, 8);
				repeat (n)
					send_token(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				counted += n;
			end
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
		quiet = 1'b0;
	endtask

	initial begin
		tok_if.valid = 1'b0;
		tok_if.func = FN_PATTERN;
		tok_if.token_value = '0;
		tok_if.token_null = 1'b0;
		tok_if.last = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_pattern_full();
		test_random();

		wait_drained();
		repeat (64) @(posedge clk);
		$display("Checked %0d result beats: %0d first matches, %0d tokens dropped on a full pattern,",
			results_seen, first_matches, full_drops);
		$display("%0d text tokens past the position limit, %0d text tokens with no pattern.",
			overlong, without_pattern);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
design/kmp_pkg.sv
design/kmp_in_if.sv
design/kmp_out_if.sv
design/kmp_ram.sv
design/kmp_token_matcher.sv
tb/kmp_token_matcher_test.sv
